FILE: sv/qmm_pkg.sv
package qmm_pkg;

  localparam int NLANE = 4;
  localparam int XW    = 60;
  localparam int ROOTW = XW / 2;
  localparam int RW    = ROOTW + 3;
  localparam int SW    = 60;
  localparam int PW    = 55;

  localparam logic [21:0]      COEF_RP      = 22'd3561737;
  localparam logic [21:0]      COEF_YAW     = 22'd2746896;
  localparam logic [XW-1:0]    CURVE_OFFSET = 60'd32699091052953600;
  localparam logic [33:0]      CURVE_SLOPE  = 34'd16333408000;
  localparam logic [ROOTW-1:0] CURVE_BIAS   = 30'd196340228;
  localparam logic [15:0]      PWM_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SAT,
    CLS_CURVE
  } cls_t;

  typedef struct packed {
    cls_t          cls;
    logic [XW-1:0] x;
  } lane_t;

  typedef lane_t [NLANE-1:0] lanes_t;

  typedef struct packed {
    cls_t             cls;
    logic [XW-1:0]    xs;
    logic [RW-1:0]    rem;
    logic [ROOTW-1:0] root;
  } sq_lane_t;

  typedef sq_lane_t [NLANE-1:0] sq_lanes_t;

  typedef logic [NLANE-1:0][15:0] pwms_t;

  function automatic sq_lane_t sq_step(sq_lane_t a);
    sq_lane_t      b;
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    b     = a;
    sh    = {a.rem[RW-3:0], a.xs[XW-1 -: 2]};
    trial = {{(RW-ROOTW-2){1'b0}}, a.root, 2'b01};
    b.xs  = {a.xs[XW-3:0], 2'b00};
    if (sh >= trial) begin
      b.rem  = sh - trial;
      b.root = {a.root[ROOTW-2:0], 1'b1};
    end else begin
      b.rem  = sh;
      b.root = {a.root[ROOTW-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

FILE: sv/qmm_front.sv
module qmm_front import qmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] collective_thrust,
  input  logic [31:0] roll_torque,
  input  logic [31:0] pitch_torque,
  input  logic [31:0] yaw_torque,
  output logic        out_valid,
  input  logic        out_ready,
  output lanes_t      out_lanes
);

  logic va, vb, vc, vd;
  logic en_a, en_b, en_c, en_d;

  logic signed [31:0] a_t, a_r, a_p, a_y;
  logic signed [31:0] b_t;
  logic signed [PW-1:0] b_r, b_p, b_y;
  cls_t [NLANE-1:0] c_cls;
  logic [NLANE-1:0][23:0] c_tq;
  lanes_t d_lanes;

  logic signed [PW-1:0] prod_r, prod_p, prod_y;
  logic signed [SW-1:0] st, sr, sp, sy;
  logic signed [SW-1:0] mix [NLANE];
  cls_t [NLANE-1:0] cls_next;
  logic [NLANE-1:0][23:0] tq_next;
  lanes_t lanes_next;
  logic [57:0] slope_prod [NLANE];

  assign en_d = !vd || out_ready;
  assign en_c = !vc || en_d;
  assign en_b = !vb || en_c;
  assign en_a = !va || en_b;
  assign full = !en_a;
  assign out_valid = vd;
  assign out_lanes = d_lanes;

  assign prod_r = a_r * $signed({1'b0, COEF_RP});
  assign prod_p = a_p * $signed({1'b0, COEF_RP});
  assign prod_y = a_y * $signed({1'b0, COEF_YAW});

  assign st = {{2{b_t[31]}}, b_t, 26'b0};
  assign sr = {{(SW-PW){b_r[PW-1]}}, b_r};
  assign sp = {{(SW-PW){b_p[PW-1]}}, b_p};
  assign sy = {{(SW-PW){b_y[PW-1]}}, b_y};
  assign mix[0] = st - sr - sp - sy;
  assign mix[1] = st - sr + sp + sy;
  assign mix[2] = st + sr + sp - sy;
  assign mix[3] = st + sr - sp + sy;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      tq_next[i] = mix[i][47:24];
      if (mix[i][SW-1] || mix[i] == '0) begin
        cls_next[i] = CLS_ZERO;
      end else if (mix[i][SW-2:48] != '0) begin
        cls_next[i] = CLS_SAT;
      end else begin
        cls_next[i] = CLS_CURVE;
      end
      slope_prod[i] = 58'(c_tq[i]) * 58'(CURVE_SLOPE);
      lanes_next[i].cls = c_cls[i];
      lanes_next[i].x   = CURVE_OFFSET + {2'b00, slope_prod[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (en_a) va <= push;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_t <= collective_thrust;
      a_r <= roll_torque;
      a_p <= pitch_torque;
      a_y <= yaw_torque;
    end
    if (en_b) begin
      b_t <= a_t;
      b_r <= prod_r;
      b_p <= prod_p;
      b_y <= prod_y;
    end
    if (en_c) begin
      c_cls <= cls_next;
      c_tq  <= tq_next;
    end
    if (en_d) d_lanes <= lanes_next;
  end

endmodule

FILE: sv/qmm_fifo.sv
module qmm_fifo import qmm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  lanes_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output lanes_t rd_data
);

  lanes_t mem [2];
  logic   wptr, rptr;
  logic [1:0] count;
  logic   do_wr, do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

endmodule

FILE: sv/qmm_back.sv
module qmm_back import qmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] idle_level,
  input  logic        in_valid,
  output logic        in_ready,
  input  lanes_t      in_lanes,
  output logic        empty,
  input  logic        pop,
  output pwms_t       pwm
);

  localparam int NS = ROOTW;

  logic [NS:0] v;
  logic [NS+1:0] en;
  sq_lanes_t st [NS+1];
  logic vo;
  pwms_t pwm_next;
  logic [ROOTW-1:0] diff [NLANE];
  logic [15:0] raw [NLANE];

  assign en[NS+1] = !vo || pop;
  for (genvar k = 0; k <= NS; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[0];
  assign empty = !vo;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      diff[i] = st[NS][i].root - CURVE_BIAS;
      unique case (st[NS][i].cls)
        CLS_SAT: raw[i] = PWM_MAX;
        CLS_CURVE: begin
          if (st[NS][i].root < CURVE_BIAS) begin
            raw[i] = '0;
          end else if (diff[i][ROOTW-1:28] != '0) begin
            raw[i] = PWM_MAX;
          end else begin
            raw[i] = diff[i][27:12];
          end
        end
        default: raw[i] = '0;
      endcase
      pwm_next[i] = (raw[i] < idle_level) ? idle_level : raw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      vo <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (en[NS+1]) vo <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NLANE; i++) begin
        st[0][i].cls  <= in_lanes[i].cls;
        st[0][i].xs   <= in_lanes[i].x;
        st[0][i].rem  <= '0;
        st[0][i].root <= '0;
      end
    end
    for (int k = 1; k <= NS; k++) begin
      if (en[k]) begin
        for (int i = 0; i < NLANE; i++) begin
          st[k][i] <= sq_step(st[k-1][i]);
        end
      end
    end
    if (en[NS+1]) pwm <= pwm_next;
  end

endmodule

FILE: sv/quad_motor_mixer_pwm_top.sv
// Quadrotor X mixer with thrust-to-PWM curve.
// Input queue side: present a command on collective_thrust, roll_torque,
// pitch_torque and yaw_torque and raise push; it is taken on a clock edge
// where full is low. Result queue side: while empty is low the four motor
// PWM values of the oldest command are on motor_*_pwm; raise pop to take them.
// Configuration: idle_level is written through cfg_valid/cfg_data,
// cfg_ready is always high; write it only while no command is in flight.
// The request passes four mixing stages, a two-slot queue, a root load
// stage, thirty square-root stages (one root bit per stage for all four
// motors) and the output register.
// Throughput is one command per cycle while pop keeps up; every stage holds one command.
// When pop stays low the result holds, stages behind it keep filling until
// every stage is occupied, and then full rises.
// Reset (rst, synchronous) empties all stages and sets idle_level to 0.
module quad_motor_mixer_pwm_top import qmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] collective_thrust,
  input  logic [31:0] roll_torque,
  input  logic [31:0] pitch_torque,
  input  logic [31:0] yaw_torque,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] motor_one_pwm,
  output logic [15:0] motor_two_pwm,
  output logic [15:0] motor_three_pwm,
  output logic [15:0] motor_four_pwm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] idle_level;
  logic   f_valid, f_ready, q_valid, q_ready;
  lanes_t f_lanes, q_lanes;
  pwms_t  pwm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      idle_level <= cfg_data;
    end
  end

  qmm_front u_front (
    .clk, .rst, .push, .full,
    .collective_thrust, .roll_torque, .pitch_torque, .yaw_torque,
    .out_valid(f_valid), .out_ready(f_ready), .out_lanes(f_lanes)
  );

  qmm_fifo u_fifo (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_lanes),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_lanes)
  );

  qmm_back u_back (
    .clk, .rst, .idle_level,
    .in_valid(q_valid), .in_ready(q_ready), .in_lanes(q_lanes),
    .empty, .pop, .pwm
  );

  assign motor_one_pwm   = pwm[0];
  assign motor_two_pwm   = pwm[1];
  assign motor_three_pwm = pwm[2];
  assign motor_four_pwm  = pwm[3];

endmodule

FILE: sv/qmm_checker.sv
module qmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] motor_one_pwm,
  input logic [15:0] motor_four_pwm
);

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("stages not cleared by reset");

  a_full_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("input blocked with no result waiting");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(motor_one_pwm) && $stable(motor_four_pwm))
    else $error("waiting result changed");

endmodule

bind quad_motor_mixer_pwm_top qmm_checker u_qmm_checker (
  .clk, .rst, .full, .empty, .pop, .motor_one_pwm, .motor_four_pwm
);
